[src/lavb_pkg.sv]
package lavb_pkg;

   localparam int COORD_W     = 32;                  // Q16.16 coordinate
   localparam int UNIT_W      = 18;                  // Q1.16 unit component
   localparam int Q_W         = 17;                  // quotient magnitude bits
   localparam int A_W         = 30;                  // normalized magnitude bits
   localparam int SQRT_STEPS  = 31;                  // one root bit per stage
   localparam int DIV_STEPS   = Q_W;                 // one quotient bit per stage
   localparam int NORM_LAT    = 6 + SQRT_STEPS + 1 + DIV_STEPS + 1;
   localparam int CROSS_LAT   = 2;
   localparam int TOTAL_LAT   = 3 * NORM_LAT + 2 * CROSS_LAT;
   localparam int BACK_W      = COORD_W + 1;         // eye minus target
   localparam int SIDE_W      = COORD_W + UNIT_W + 1;
   localparam int UPW_W       = 2 * UNIT_W + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int REQ_W       = 9 * COORD_W;
   localparam int RSP_W       = 264;

   typedef struct packed {
      logic [2:0][BACK_W-1:0]  back_raw;
      logic [2:0][COORD_W-1:0] up;
      logic [2:0][COORD_W-1:0] shift;
   } work_type;

   typedef struct packed {
      logic [2:0][UNIT_W-1:0]  side;
      logic [2:0][UNIT_W-1:0]  upward;
      logic [2:0][UNIT_W-1:0]  back;
      logic [2:0][COORD_W-1:0] shift;
   } result_type;

endpackage

[src/lavb_delay.sv]
module lavb_delay import lavb_pkg::*; #(
   parameter int W = 1,
   parameter int D = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] sr_ff [D];

   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff[0] <= d;
         for (int k = 1; k < D; k++) begin
            sr_ff[k] <= sr_ff[k-1];
         end
      end
   end

   assign q = sr_ff[D-1];

endmodule

[src/lavb_front.sv]
module lavb_front import lavb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             pop,
   output logic             head_valid,
   output work_type         head
);

   localparam logic [1:0] FULL = 2'(QUEUE_DEPTH);

   work_type   q_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff, cnt_in;
   work_type   entry_in;
   logic       push, do_pop;

   // form eye minus target and the saturated negated eye
   always_comb begin
      logic [COORD_W-1:0] eye, tgt;
      for (int i = 0; i < 3; i++) begin
         eye = req_tdata[i*COORD_W +: COORD_W];
         tgt = req_tdata[(3+i)*COORD_W +: COORD_W];
         entry_in.up[i]       = req_tdata[(6+i)*COORD_W +: COORD_W];
         entry_in.back_raw[i] = {eye[COORD_W-1], eye} - {tgt[COORD_W-1], tgt};
         entry_in.shift[i]    = (eye == {1'b1, {(COORD_W-1){1'b0}}}) ?
                                {1'b0, {(COORD_W-1){1'b1}}} : COORD_W'(0) - eye;
      end
   end

   assign req_tready = (cnt_ff != FULL);
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = q_ff[rd_ptr_ff];
   assign push       = req_tvalid & req_tready;
   assign do_pop     = pop & head_valid;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

[src/lavb_cross.sv]
module lavb_cross import lavb_pkg::*; #(
   parameter int AW = 32,
   parameter int BW = 18
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [2:0][AW-1:0]       a,
   input  logic [2:0][BW-1:0]       b,
   output logic [2:0][AW+BW:0]      o
);

   localparam int PW = AW + BW;
   localparam int OW = AW + BW + 1;

   logic signed [PW-1:0] pr_ff [6];
   logic [2:0][OW-1:0]   o_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pr_ff[0] <= $signed(a[1]) * $signed(b[2]);
         pr_ff[1] <= $signed(a[2]) * $signed(b[1]);
         pr_ff[2] <= $signed(a[2]) * $signed(b[0]);
         pr_ff[3] <= $signed(a[0]) * $signed(b[2]);
         pr_ff[4] <= $signed(a[0]) * $signed(b[1]);
         pr_ff[5] <= $signed(a[1]) * $signed(b[0]);
         o_ff[0]  <= OW'(pr_ff[0]) - OW'(pr_ff[1]);
         o_ff[1]  <= OW'(pr_ff[2]) - OW'(pr_ff[3]);
         o_ff[2]  <= OW'(pr_ff[4]) - OW'(pr_ff[5]);
      end
   end

   assign o = o_ff;

endmodule

[src/lavb_norm.sv]
module lavb_norm import lavb_pkg::*; #(
   parameter int IN_W = 33
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [2:0][IN_W-1:0]     vec_in,
   output logic [2:0][UNIT_W-1:0]   vec_out
);

   localparam int PW   = $clog2(IN_W);
   localparam int RM_W = 2 * A_W + 3;
   localparam int SQ_W = 2 * A_W;
   localparam int DR_W = A_W + Q_W + 2;
   localparam int DN_W = SQRT_STEPS + 1;
   localparam logic [PW-1:0] TOP_BIT = PW'(A_W - 1);

   logic [2:0]             neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff;
   logic [2:0][IN_W-1:0]   mag1_ff, mag2_ff, mag3_ff;
   logic [IN_W-1:0]        max2_ff;
   logic [PW-1:0]          pos3_ff;
   logic                   zero3_ff, zero4_ff, zero5_ff;
   logic [2:0][A_W-1:0]    a4_ff, a5_ff;
   logic [2:0][SQ_W-1:0]   sq5_ff;

   logic [RM_W-2:0]        rem_ff  [0:SQRT_STEPS];
   logic [SQRT_STEPS-1:0]  root_ff [0:SQRT_STEPS];
   logic [2:0][A_W-1:0]    sa_ff   [0:SQRT_STEPS];
   logic [2:0]             sneg_ff [0:SQRT_STEPS];
   logic                   szero_ff[0:SQRT_STEPS];
   logic [RM_W-2:0]        rem_in  [0:SQRT_STEPS-1];
   logic [SQRT_STEPS-1:0]  root_in [0:SQRT_STEPS-1];

   logic [2:0][DR_W-1:0]   drem_ff [0:DIV_STEPS];
   logic [2:0][Q_W-1:0]    quo_ff  [0:DIV_STEPS];
   logic [DN_W-1:0]        den_ff  [0:DIV_STEPS];
   logic [2:0]             dneg_ff [0:DIV_STEPS];
   logic                   dzero_ff[0:DIV_STEPS];
   logic [2:0][DR_W-1:0]   drem_in [0:DIV_STEPS-1];
   logic [2:0][Q_W-1:0]    quo_in  [0:DIV_STEPS-1];

   logic [2:0][IN_W-1:0]   mag_in;
   logic [IN_W-1:0]        max_in;
   logic [PW-1:0]          pos_in;
   logic [2:0][A_W-1:0]    a_in;
   logic [2:0][UNIT_W-1:0] vec_ff;

   // front stages: magnitude, largest magnitude, its top bit, scale
   always_comb begin
      logic [IN_W-1:0] t;
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = vec_in[i][IN_W-1] ? IN_W'(0) - vec_in[i] : vec_in[i];
      end
      max_in = (mag1_ff[0] > mag1_ff[1]) ? mag1_ff[0] : mag1_ff[1];
      max_in = (mag1_ff[2] > max_in) ? mag1_ff[2] : max_in;
      pos_in = '0;
      for (int b = 0; b < IN_W; b++) begin
         if (max2_ff[b]) begin
            pos_in = PW'(b);
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (pos3_ff > TOP_BIT) begin
            t = mag3_ff[i] >> (pos3_ff - TOP_BIT);
         end else begin
            t = mag3_ff[i] << (TOP_BIT - pos3_ff);
         end
         a_in[i] = t[A_W-1:0];
      end
   end

   // square root: one root bit per stage, restoring
   always_comb begin
      logic [RM_W-1:0] trial;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         trial = (RM_W'(root_ff[k]) << (SQRT_STEPS - k))
               + (RM_W'(1) << (2 * (SQRT_STEPS - 1 - k)));
         if (RM_W'(rem_ff[k]) >= trial) begin
            rem_in[k]  = rem_ff[k] - trial[RM_W-2:0];
            root_in[k] = root_ff[k] | (SQRT_STEPS'(1) << (SQRT_STEPS - 1 - k));
         end else begin
            rem_in[k]  = rem_ff[k];
            root_in[k] = root_ff[k];
         end
      end
   end

   // division: one quotient bit per stage, restoring
   always_comb begin
      logic [DR_W-1:0] d;
      for (int k = 0; k < DIV_STEPS; k++) begin
         d = DR_W'(den_ff[k]) << (DIV_STEPS - 1 - k);
         for (int i = 0; i < 3; i++) begin
            if (drem_ff[k][i] >= d) begin
               drem_in[k][i] = drem_ff[k][i] - d;
               quo_in[k][i]  = quo_ff[k][i] | (Q_W'(1) << (DIV_STEPS - 1 - k));
            end else begin
               drem_in[k][i] = drem_ff[k][i];
               quo_in[k][i]  = quo_ff[k][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            neg1_ff[i] <= vec_in[i][IN_W-1];
            sq5_ff[i]  <= a4_ff[i] * a4_ff[i];
         end
         mag1_ff  <= mag_in;
         neg2_ff  <= neg1_ff;
         mag2_ff  <= mag1_ff;
         max2_ff  <= max_in;
         neg3_ff  <= neg2_ff;
         mag3_ff  <= mag2_ff;
         pos3_ff  <= pos_in;
         zero3_ff <= (max2_ff == '0);
         neg4_ff  <= neg3_ff;
         a4_ff    <= a_in;
         zero4_ff <= zero3_ff;
         neg5_ff  <= neg4_ff;
         a5_ff    <= a4_ff;
         zero5_ff <= zero4_ff;

         rem_ff[0]   <= (RM_W-1)'(sq5_ff[0]) + (RM_W-1)'(sq5_ff[1])
                      + (RM_W-1)'(sq5_ff[2]);
         root_ff[0]  <= '0;
         sa_ff[0]    <= a5_ff;
         sneg_ff[0]  <= neg5_ff;
         szero_ff[0] <= zero5_ff;
         for (int k = 0; k < SQRT_STEPS; k++) begin
            rem_ff[k+1]   <= rem_in[k];
            root_ff[k+1]  <= root_in[k];
            sa_ff[k+1]    <= sa_ff[k];
            sneg_ff[k+1]  <= sneg_ff[k];
            szero_ff[k+1] <= szero_ff[k];
         end

         // numerator a*2^17 + L over 2L rounds a/L half away from zero
         for (int i = 0; i < 3; i++) begin
            drem_ff[0][i] <= (DR_W'(sa_ff[SQRT_STEPS][i]) << Q_W)
                           + DR_W'(root_ff[SQRT_STEPS]);
            quo_ff[0][i]  <= '0;
         end
         den_ff[0]   <= {root_ff[SQRT_STEPS], 1'b0};
         dneg_ff[0]  <= sneg_ff[SQRT_STEPS];
         dzero_ff[0] <= szero_ff[SQRT_STEPS];
         for (int k = 0; k < DIV_STEPS; k++) begin
            drem_ff[k+1]  <= drem_in[k];
            quo_ff[k+1]   <= quo_in[k];
            den_ff[k+1]   <= den_ff[k];
            dneg_ff[k+1]  <= dneg_ff[k];
            dzero_ff[k+1] <= dzero_ff[k];
         end

         // drop the quotient of a zero vector, restore signs
         for (int i = 0; i < 3; i++) begin
            if (dzero_ff[DIV_STEPS]) begin
               vec_ff[i] <= '0;
            end else if (dneg_ff[DIV_STEPS][i]) begin
               vec_ff[i] <= UNIT_W'(0) - UNIT_W'(quo_ff[DIV_STEPS][i]);
            end else begin
               vec_ff[i] <= UNIT_W'(quo_ff[DIV_STEPS][i]);
            end
         end
      end
   end

   assign vec_out = vec_ff;

endmodule

[src/look_at_view_basis_top.sv]
// Look-at camera basis. Each request carries an eye point, a target point
// and an up direction, all signed Q16.16. Each response carries the
// normalized side, recomputed up and back axes as signed Q1.16, and the
// negated eye position saturated to the symmetric Q16.16 range.
//
// Channels: req_* is the request stream, rsp_* the response stream; a
// request is taken when tvalid and tready are both high. One response
// leaves per request, in request order.
//
// Throughput: one request per cycle while the response side keeps up.
// Path from request to response: two-entry front queue, three
// normalizers of 56 stages each, dominated by the 31-stage square root
// and 17-stage divider, two 2-stage cross products, output buffer.
//
// A two-entry output buffer takes the pipeline's results. When the
// receiver stalls, the buffer fills and the whole pipeline holds; the
// front queue then fills and req_tready drops. Reset empties the queue,
// the pipeline and the buffer; no request is in flight afterward.
module look_at_view_basis_top import lavb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // side_x, side_y, side_z, upward_x, upward_y, upward_z,
   // back_x, back_y, back_z, shift_x, shift_y, shift_z, zero pad
   output logic [RSP_W-1:0] rsp_tdata
);

   logic                        adv;
   logic                        head_valid;
   work_type                    head;
   logic [TOTAL_LAT-1:0]        vld_ff;

   logic [2:0][UNIT_W-1:0]      back_n, back_d1, back_d2;
   logic [2:0][UNIT_W-1:0]      side_n, side_d;
   logic [2:0][UNIT_W-1:0]      upw_n;
   logic [2:0][COORD_W-1:0]     up_d, shift_d;
   logic [2:0][SIDE_W-1:0]      side_raw;
   logic [2:0][UPW_W-1:0]       upw_raw;

   result_type                  ob_ff [2];
   result_type                  res;
   logic                        owr_ff, ord_ff;
   logic [1:0]                  ocnt_ff, ocnt_in;
   logic                        opush, opop;

   // advance the whole pipeline while the output buffer has room
   assign adv = (ocnt_ff != 2'd2);

   lavb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .pop        (adv),
      .head_valid (head_valid),
      .head       (head)
   );

   lavb_norm #(.IN_W(BACK_W)) u_norm_back (
      .clock (clock), .en (adv), .vec_in (head.back_raw), .vec_out (back_n)
   );

   lavb_delay #(.W(3*COORD_W), .D(NORM_LAT)) u_up_dly (
      .clock (clock), .en (adv), .d (head.up), .q (up_d)
   );

   lavb_cross #(.AW(COORD_W), .BW(UNIT_W)) u_cross_side (
      .clock (clock), .en (adv), .a (up_d), .b (back_n), .o (side_raw)
   );

   lavb_norm #(.IN_W(SIDE_W)) u_norm_side (
      .clock (clock), .en (adv), .vec_in (side_raw), .vec_out (side_n)
   );

   lavb_delay #(.W(3*UNIT_W), .D(NORM_LAT+CROSS_LAT)) u_back_dly1 (
      .clock (clock), .en (adv), .d (back_n), .q (back_d1)
   );

   lavb_cross #(.AW(UNIT_W), .BW(UNIT_W)) u_cross_up (
      .clock (clock), .en (adv), .a (back_d1), .b (side_n), .o (upw_raw)
   );

   lavb_norm #(.IN_W(UPW_W)) u_norm_up (
      .clock (clock), .en (adv), .vec_in (upw_raw), .vec_out (upw_n)
   );

   lavb_delay #(.W(3*UNIT_W), .D(NORM_LAT+CROSS_LAT)) u_back_dly2 (
      .clock (clock), .en (adv), .d (back_d1), .q (back_d2)
   );

   lavb_delay #(.W(3*UNIT_W), .D(NORM_LAT+CROSS_LAT)) u_side_dly (
      .clock (clock), .en (adv), .d (side_n), .q (side_d)
   );

   lavb_delay #(.W(3*COORD_W), .D(TOTAL_LAT)) u_shift_dly (
      .clock (clock), .en (adv), .d (head.shift), .q (shift_d)
   );

   // track which pipeline slots hold a live request
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[TOTAL_LAT-2:0], head_valid};
      end
   end

   assign res.side   = side_d;
   assign res.upward = upw_n;
   assign res.back   = back_d2;
   assign res.shift  = shift_d;

   assign opush = adv & vld_ff[TOTAL_LAT-1];
   assign opop  = rsp_tvalid & rsp_tready;

   always_comb begin
      ocnt_in = ocnt_ff;
      if (opush && !opop) begin
         ocnt_in = ocnt_ff + 2'd1;
      end else if (opop && !opush) begin
         ocnt_in = ocnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ocnt_ff <= 2'd0;
         owr_ff  <= 1'b0;
         ord_ff  <= 1'b0;
      end else begin
         ocnt_ff <= ocnt_in;
         if (opush) begin
            owr_ff <= ~owr_ff;
         end
         if (opop) begin
            ord_ff <= ~ord_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (opush) begin
         ob_ff[owr_ff] <= res;
      end
   end

   assign rsp_tvalid = (ocnt_ff != 2'd0);

   // pack the response, first field in the lowest bits
   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < 3; i++) begin
         rsp_tdata[i*UNIT_W +: UNIT_W]       = ob_ff[ord_ff].side[i];
         rsp_tdata[(3+i)*UNIT_W +: UNIT_W]   = ob_ff[ord_ff].upward[i];
         rsp_tdata[(6+i)*UNIT_W +: UNIT_W]   = ob_ff[ord_ff].back[i];
         rsp_tdata[9*UNIT_W + i*COORD_W +: COORD_W] = ob_ff[ord_ff].shift[i];
      end
   end

   a_ocnt_range: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff != 2'd3)
      else $error("output buffer count out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(opush && ocnt_ff == 2'd2))
      else $error("push into a full output buffer");

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      (ocnt_ff == 2'd2) |=> $stable(vld_ff))
      else $error("pipeline moved while output buffer full");

   a_side_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[UNIT_W-1:0]) <= 18'sd65536)
                  && ($signed(rsp_tdata[UNIT_W-1:0]) >= -18'sd65536))
      else $error("side_x exceeds unit range");

   a_shift_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[9*UNIT_W +: COORD_W] != {1'b1, {(COORD_W-1){1'b0}}})
      else $error("shift_x not saturated");

endmodule

[dv/look_at_view_basis_top_tb.sv]
module look_at_view_basis_top_tb import lavb_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM    = 530;
   localparam int QUIET_FROM  = 480;   // no idling on either side past this request
   localparam int STALL_AT    = 150;   // receiver holds off here
   localparam int STALL_LEN   = 400;
   localparam int DRAIN_AT    = 320;   // sender waits for an empty pipe here
   localparam int WDOG_LIMIT  = 4000;
   localparam int N_FIELDS    = 12;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;
   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_ONE = 32'h0001_0000;

   // One camera request: eye, target, up, three components each
   typedef struct {
      logic [31:0] coord[9];
   } camera_t;

   // One basis: side, upward, back (Q1.16), shift (Q16.16), as signed values
   typedef struct {
      longint f[N_FIELDS];
   } basis_t;

   typedef struct {
      camera_t cam;
      bit      typed;
      basis_t  want;
   } dir_row_t;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;

   basis_t   pending_basis[$];
   dir_row_t dir_rows[$];
   int       mismatches = 0;
   int       responses  = 0;
   int       requests   = 0;
   int       idle_cycles = 0;
   bit       quiet = 0;
   bit       stall_now = 0;
   int       n_zero_back = 0;
   int       n_zero_side = 0;

   look_at_view_basis_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Integer square root, floor
   function automatic longint unsigned floor_sqrt(input longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Scale a raw vector to unit length in Q1.16, rounding half away from zero.
   // A zero vector stays zero.
   function automatic void unit_vec(input longint v[3], output longint o[3]);
      longint unsigned a[3];
      longint unsigned top, sum, len, q;
      bit neg[3];
      int rs, ls;
      top = 0;
      sum = 0;
      rs = 0;
      ls = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         a[i] = neg[i] ? -v[i] : v[i];
         if (a[i] > top) top = a[i];
      end
      if (top == 0) begin
         o = '{0, 0, 0};
         return;
      end
      while ((top >> rs) >= (64'd1 << 30)) rs++;
      if (rs == 0)
         while ((top << ls) < (64'd1 << 29)) ls++;
      for (int i = 0; i < 3; i++) begin
         a[i] = (a[i] >> rs) << ls;
         sum += a[i] * a[i];
      end
      len = floor_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = (2 * a[i] * 65536 + len) / (2 * len);
         o[i] = neg[i] ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic void cross_prod(input longint a[3], input longint b[3],
                                      output longint o[3]);
      o[0] = a[1] * b[2] - a[2] * b[1];
      o[1] = a[2] * b[0] - a[0] * b[2];
      o[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic basis_t camera_basis(input camera_t c);
      basis_t r;
      longint eye[3], up[3], back_raw[3], back_n[3];
      longint side_raw[3], side_n[3], upw_raw[3], upw_n[3];
      for (int i = 0; i < 3; i++) begin
         eye[i] = longint'($signed(c.coord[i]));
         up[i]  = longint'($signed(c.coord[6 + i]));
         back_raw[i] = eye[i] - longint'($signed(c.coord[3 + i]));
      end
      unit_vec(back_raw, back_n);
      cross_prod(up, back_n, side_raw);
      unit_vec(side_raw, side_n);
      cross_prod(back_n, side_n, upw_raw);
      unit_vec(upw_raw, upw_n);
      for (int i = 0; i < 3; i++) begin
         r.f[i]     = side_n[i];
         r.f[3 + i] = upw_n[i];
         r.f[6 + i] = back_n[i];
         r.f[9 + i] = (-eye[i] > 64'sd2147483647) ? 64'sd2147483647 : -eye[i];
      end
      return r;
   endfunction

   function automatic basis_t shift_only(input longint sx, input longint sy,
                                         input longint sz);
      basis_t r;
      foreach (r.f[k]) r.f[k] = 0;
      r.f[9]  = sx;
      r.f[10] = sy;
      r.f[11] = sz;
      return r;
   endfunction

   task automatic add_row(input logic [31:0] c[9], input bit typed, input basis_t want);
      dir_row_t row;
      row.cam.coord = c;
      row.typed = typed;
      row.want = want;
      dir_rows.push_back(row);
   endtask

   function automatic logic [31:0] pick_coord(input int mode);
      case (mode)
         0: return $urandom();
         1: return $urandom_range(0, 2 ** 21) - 32'd1048576;
         default: begin
            case ($urandom_range(0, 5))
               0: return Q_MIN;
               1: return Q_MAX;
               2: return 32'd0;
               3: return 32'hFFFF_FFFF;
               4: return Q_ONE;
               default: return 32'd1;
            endcase
         end
      endcase
   endfunction

   // Full-range scenes half the time; otherwise small scenes, eye on target,
   // up along the view direction and corner values
   function automatic camera_t random_camera();
      camera_t c;
      int kind;
      int mode;
      int k;
      kind = $urandom_range(0, 9);
      mode = (kind <= 4) ? 0 : (kind == 9) ? 2 : 1;
      for (int i = 0; i < 9; i++) c.coord[i] = pick_coord(mode);
      if (kind == 7) begin
         for (int i = 0; i < 3; i++) c.coord[3 + i] = c.coord[i];
      end else if (kind == 8) begin
         k = $urandom_range(1, 7) - 4;
         for (int i = 0; i < 3; i++)
            c.coord[6 + i] = (c.coord[i] - c.coord[3 + i]) * k;
      end
      return c;
   endfunction

   // Offer one request and hold it until it is taken; record its basis
   task automatic offer(input camera_t c, input basis_t want);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      for (int i = 0; i < 9; i++) req_tdata[32 * i +: 32] <= c.coord[i];
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_basis.push_back(want);
      requests++;
      if (want.f[6] == 0 && want.f[7] == 0 && want.f[8] == 0) n_zero_back++;
      else if (want.f[0] == 0 && want.f[1] == 0 && want.f[2] == 0) n_zero_side++;
      @(negedge clock);
   endtask

   // Receiver: random short stalls, one long hold-off, none near the end
   int hold_left = 0;
   always @(negedge clock) begin
      if (stall_now) begin
         stall_now = 1'b0;
         hold_left = STALL_LEN;
      end else if (hold_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
         hold_left = $urandom_range(1, 5);
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check each response against the oldest pending basis, field by field
   always @(posedge clock) begin
      basis_t want;
      longint got, exp;
      int w, off;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses++;
         if (pending_basis.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response %0d with no request pending", responses);
         end else begin
            want = pending_basis.pop_front();
            for (int k = 0; k < N_FIELDS; k++) begin
               w   = (k < 9) ? UNIT_W : COORD_W;
               off = (k < 9) ? UNIT_W * k : 9 * UNIT_W + COORD_W * (k - 9);
               got = longint'(rsp_tdata[off +: 32]) & ((64'd1 << w) - 1);
               exp = want.f[k] & ((64'd1 << w) - 1);
               if (got !== exp) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response %0d field %0d: expected %h, got %h",
                              responses, k, exp, got);
               end
            end
         end
      end
   end

   // Watchdog: end the run after too many cycles with no transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_LIMIT) begin
         $display("timeout: %0d requests pending", pending_basis.size());
         $display("look_at_view_basis_top_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      camera_t c;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;

      // Directed scenes
      add_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, shift_only(0, 0, 0));
      // eye on target at the most negative corner: shift saturates
      add_row('{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, Q_ONE, 0}, 1,
              shift_only(2147483647, 2147483647, 2147483647));
      // eye on +z looking at the origin, up along +y: identity basis
      begin
         basis_t b;
         b = shift_only(0, 0, -65536);
         b.f[0] = 65536;
         b.f[4] = 65536;
         b.f[8] = 65536;
         add_row('{0, 0, Q_ONE, 0, 0, 0, 0, Q_ONE, 0}, 1, b);
         // up parallel to the view direction: side and upward vanish
         b = shift_only(0, 0, -65536);
         b.f[8] = 65536;
         add_row('{0, 0, Q_ONE, 0, 0, 0, 0, 0, 3}, 1, b);
      end
      add_row('{Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX}, 0, shift_only(0, 0, 0));
      add_row('{Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, 0, Q_MAX}, 0, shift_only(0, 0, 0));
      add_row('{Q_MIN, 0, Q_MAX, Q_MAX, 0, Q_MIN, Q_MAX, Q_MAX, Q_MIN}, 0, shift_only(0, 0, 0));
      add_row('{-1, -1, -1, 0, 0, 0, 1, 0, 0}, 0, shift_only(0, 0, 0));
      add_row('{1, 0, 0, 0, 0, 0, 0, 0, 1}, 0, shift_only(0, 0, 0));
      add_row('{Q_MAX, 0, 0, 0, Q_MAX, 0, 0, 0, Q_MAX}, 0, shift_only(0, 0, 0));
      add_row('{32'h0003_0000, 32'h0002_8000, -32'sd65536, 0, 32'h0001_0000, 0,
                0, Q_ONE, 0}, 0, shift_only(0, 0, 0));
      add_row('{-1, -1, -1, -1, -1, -1, -1, -1, -1}, 0, shift_only(0, 0, 0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the table; typed rows carry their own basis, the rest are predicted
      foreach (dir_rows[r])
         offer(dir_rows[r].cam,
               dir_rows[r].typed ? dir_rows[r].want : camera_basis(dir_rows[r].cam));

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == STALL_AT) stall_now = 1'b1;
         if (n == DRAIN_AT) begin
            // pause the sender until every response is back
            req_tvalid <= 1'b0;
            while (pending_basis.size() != 0) @(negedge clock);
         end
         if (n == QUIET_FROM) quiet = 1'b1;
         c = random_camera();
         offer(c, camera_basis(c));
      end
      req_tvalid <= 1'b0;

      while (pending_basis.size() != 0) @(posedge clock);
      repeat (TOTAL_LAT + 20) @(posedge clock);

      $display("covered %0d requests, %0d responses: %0d with eye on target,",
               requests, responses, n_zero_back);
      $display("%0d with up along the view axis, one long receiver stall, one drain",
               n_zero_side);
      if (mismatches == 0 && pending_basis.size() == 0) begin
         $display("look_at_view_basis_top_tb OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("look_at_view_basis_top_tb NOT OK");
      end
      $finish;
   end

endmodule
